// ===== rtl/uhrd_pkg.sv =====
// Shared types, constants and the header check for the USB HID report deframer.
// No dependencies; uhrd_rx and the top level import this package.
package uhrd_pkg;

   localparam int REPORT_BYTES = 64;
   localparam int HEADER_BYTES = 11;
   localparam int PAYLOAD_MAX  = REPORT_BYTES - HEADER_BYTES;
   localparam int POS_W        = $clog2(REPORT_BYTES + 1);
   localparam int PAYLOAD_AW   = $clog2(PAYLOAD_MAX);
   localparam int LEN_W        = $clog2(PAYLOAD_MAX + 1);

   localparam int REG_RAW_MODE    = 0;
   localparam int REG_EMI_VERSION = 1;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_DROP    = 2'd2
   } kind_type;

   // Result or playout request produced by the receive side for one transfer.
   typedef struct packed {
      logic             res_valid;
      logic [7:0]       res_byte;
      kind_type         res_kind;
      logic             res_last;
      logic             emit_start;
      logic [LEN_W-1:0] emit_len;
   } rx_evt_type;

   function automatic logic hdr_byte_ok(input logic [POS_W-1:0] pos,
                                        input logic [7:0] b,
                                        input logic [1:0] emi);
      logic ok;
      begin
         case (pos)
            POS_W'(0): ok = (b == 8'h01);
            POS_W'(1): ok = ((b & 8'h0f) == 8'h03);
            POS_W'(2): ok = (b <= 8'(REPORT_BYTES - 8));
            POS_W'(3): ok = (b == 8'h00);
            POS_W'(4): ok = (b == 8'h08);
            POS_W'(5): ok = (b == 8'h00);
            POS_W'(6): ok = (b <= 8'(PAYLOAD_MAX));
            POS_W'(7): ok = (b == 8'h01);
            POS_W'(8): ok = (emi != 2'd0) && (b == {6'd0, emi});
            default:   ok = 1'b1;
         endcase
         return ok;
      end
   endfunction

endpackage

// ===== rtl/uhrd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module uhrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Read data holds until the next read.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/uhrd_rx.sv =====
// Receive side of the deframer: byte position, header checks, payload writes.
// Depends on uhrd_pkg.
module uhrd_rx (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_fire,
   input  logic [7:0]                        data_byte,
   input  logic                              end_of_report,
   input  logic                              raw_mode,
   input  logic [1:0]                        emi_version,
   output logic                              wr_en,
   output logic [uhrd_pkg::PAYLOAD_AW-1:0]   wr_addr,
   output logic [7:0]                        wr_data,
   output uhrd_pkg::rx_evt_type              evt
);
   import uhrd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             good_ff, good_in;
   logic [LEN_W-1:0] len_ff, len_in;

   logic             in_range;
   logic             good_now;
   logic [LEN_W-1:0] len_now;
   logic             exact;
   logic [POS_W-1:0] payload_off;

   assign in_range    = (pos_ff < POS_W'(REPORT_BYTES));
   assign good_now    = good_ff && in_range && hdr_byte_ok(pos_ff, data_byte, emi_version);
   assign len_now     = (in_range && pos_ff == POS_W'(6)) ? data_byte[LEN_W-1:0] : len_ff;
   assign exact       = (pos_ff == POS_W'(REPORT_BYTES - 1)) && good_now;
   assign payload_off = pos_ff - POS_W'(HEADER_BYTES);

   assign wr_en   = in_fire && !raw_mode && in_range && (pos_ff >= POS_W'(HEADER_BYTES));
   assign wr_addr = payload_off[PAYLOAD_AW-1:0];
   assign wr_data = data_byte;

   always_comb begin
      pos_in  = pos_ff;
      good_in = good_ff;
      len_in  = len_ff;
      evt     = '{res_valid: 1'b0, res_byte: 8'd0, res_kind: KIND_PAYLOAD,
                  res_last: 1'b0, emit_start: 1'b0, emit_len: '0};
      if (in_fire) begin
         if (raw_mode) begin
            evt.res_valid = 1'b1;
            evt.res_byte  = data_byte;
            evt.res_last  = end_of_report;
         end else begin
            len_in = len_now;
            if (end_of_report) begin
               pos_in  = '0;
               good_in = 1'b1;
               if (!exact) begin
                  evt.res_valid = 1'b1;
                  evt.res_kind  = KIND_DROP;
                  evt.res_last  = 1'b1;
               end else if (len_now == '0) begin
                  evt.res_valid = 1'b1;
                  evt.res_kind  = KIND_EMPTY;
                  evt.res_last  = 1'b1;
               end else begin
                  evt.emit_start = 1'b1;
                  evt.emit_len   = len_now;
               end
            end else begin
               // The position saturates at the report size; later bytes only spoil it.
               pos_in  = in_range ? pos_ff + POS_W'(1) : pos_ff;
               good_in = good_now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         good_ff <= 1'b1;
         len_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         good_ff <= good_in;
         len_ff  <= len_in;
      end
   end

endmodule

// ===== rtl/usb_hid_report_deframer.sv =====
// Top level of the USB HID report deframer: configuration, payload RAM, playout and
// the output register. Depends on uhrd_pkg, uhrd_rx and uhrd_ram.

// While a report is being received the block takes one byte per cycle when the
// output is free, with the header checked as it arrives and the payload bytes
// written into a 53-entry RAM. Outside raw mode a report end gives one result: a
// drop, an empty frame, or the start of a payload playout. A playout reads the RAM
// through its single read port at one byte per cycle while results are taken, and
// input is held off until the last payload byte is loaded into the output. The
// output is a single register that raw-mode bytes also pass through, and a byte is
// taken in the receive state when the register is empty or is being emptied.
module usb_hid_report_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_report
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] out_kind
   output logic       rsp_tlast,   // out_last
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [1:0] csr_wr_data
);
   import uhrd_pkg::*;

   typedef enum logic {
      ST_RX,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic             raw_ff, raw_in;
   logic [1:0]       emi_ff, emi_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   kind_type         out_kind_ff, out_kind_in;
   logic             out_last_ff, out_last_in;
   logic [LEN_W-1:0] rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             pend_ff, pend_in;
   logic             pend_last_ff, pend_last_in;

   logic                  out_free;
   logic                  in_fire;
   logic                  load_pend;
   logic                  issue;
   logic                  wr_en;
   logic [PAYLOAD_AW-1:0] wr_addr;
   logic [7:0]            wr_data;
   logic [7:0]            rd_data;
   rx_evt_type            evt;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_RX) && out_free;
   assign in_fire    = req_tvalid && req_tready;

   uhrd_rx u_rx (
      .clock         (clock),
      .reset         (reset),
      .in_fire       (in_fire),
      .data_byte     (req_tdata),
      .end_of_report (req_tlast),
      .raw_mode      (raw_ff),
      .emi_version   (emi_ff),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .evt           (evt)
   );

   // A read is issued when the previous read data has been or is being moved out.
   assign load_pend = (state_ff == ST_EMIT) && pend_ff && out_free;
   assign issue     = (state_ff == ST_EMIT) && (rd_idx_ff != len_ff) && (!pend_ff || load_pend);

   uhrd_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_MAX)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[PAYLOAD_AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      raw_in = raw_ff;
      emi_in = emi_ff;
      if (csr_wr_en) begin
         case (csr_index)
            1'(REG_RAW_MODE):    raw_in = csr_wr_data[0];
            1'(REG_EMI_VERSION): emi_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_free ? 1'b0 : out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      rd_idx_in    = rd_idx_ff;
      len_in       = len_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      case (state_ff)
         ST_RX: begin
            if (in_fire && evt.res_valid) begin
               out_valid_in = 1'b1;
               out_byte_in  = evt.res_byte;
               out_kind_in  = evt.res_kind;
               out_last_in  = evt.res_last;
            end
            if (in_fire && evt.emit_start) begin
               state_in  = ST_EMIT;
               rd_idx_in = '0;
               len_in    = evt.emit_len;
               pend_in   = 1'b0;
            end
         end
         ST_EMIT: begin
            if (load_pend) begin
               out_valid_in = 1'b1;
               out_byte_in  = rd_data;
               out_kind_in  = KIND_PAYLOAD;
               out_last_in  = pend_last_ff;
               pend_in      = 1'b0;
               if (pend_last_ff) begin
                  state_in = ST_RX;
               end
            end
            if (issue) begin
               pend_in      = 1'b1;
               pend_last_in = (rd_idx_ff + LEN_W'(1) == len_ff);
               rd_idx_in    = rd_idx_ff + LEN_W'(1);
            end
         end
         default: state_in = ST_RX;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RX;
         raw_ff       <= 1'b0;
         emi_ff       <= 2'd1;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rd_idx_ff    <= '0;
         len_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         raw_ff       <= raw_in;
         emi_ff       <= emi_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         rd_idx_ff    <= rd_idx_in;
         len_ff       <= len_in;
      end
      out_byte_ff <= out_byte_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
